// ===== src/sitd_pkg.sv =====
// Shared types and constants for the signed integer to decimal text block.
// No dependencies.
`timescale 1ns / 1ps

package sitd_pkg;

   localparam int unsigned VALUE_W = 32;
   localparam int unsigned CHAR_W  = 6;
   localparam int unsigned POS_W   = 4;   // digit position 0..9
   localparam int unsigned WIDE_W  = 34;  // holds 9 * 10^9

   localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

   // Powers of ten, indexed by digit position.
   localparam logic [WIDE_W-1:0] POW10 [10] = '{
      34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
      34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
   };

   // One classified value on its way from the front to the back.
   typedef struct packed {
      logic                 neg;  // emit a minus sign first
      logic [VALUE_W-1:0]   mag;  // magnitude, unsigned
      logic [POS_W-1:0]     top;  // position of the leading digit
   } item_type;

endpackage

// ===== src/signed_int_to_decimal_ascii_top.sv =====
// Top level of the signed integer to decimal text block.
// Depends on sitd_pkg, sitd_front, sitd_queue and sitd_back.
`timescale 1ns / 1ps

// Renders each 32-bit two's complement value on the req_ channel as decimal
// ASCII text on the rsp_ channel, one character per transfer, leading digit
// first: a minus sign ahead of negative values, no leading zeros, zero as a
// single '0', and the most negative value as "-2147483648". rsp_last_char
// marks the final character of each value, which has 1 to 11 characters.
// The back end sends one character per cycle through its output register
// while rsp_ready does not hold it back; the front end classifies the next
// values meanwhile and parks them in the queue (QUEUE_DEPTH entries), so a
// run of values streams out with no gap between them. A value goes through
// the front register, the queue, the back digit state and the output register.
module signed_int_to_decimal_ascii_top import sitd_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [CHAR_W-1:0]         rsp_text_char,
   output logic                      rsp_last_char
);

   // Front to queue.
   logic     fq_valid, fq_ready;
   item_type fq_item;
   // Queue to back.
   logic     qb_valid, qb_ready;
   item_type qb_item;

   // Classify: sign, magnitude and position of the leading digit.
   sitd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .out_valid (fq_valid),
      .out_ready (fq_ready),
      .out_item  (fq_item)
   );

   // Hold classified values while the back end is still emitting.
   sitd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fq_valid),
      .in_ready  (fq_ready),
      .in_item   (fq_item),
      .out_valid (qb_valid),
      .out_ready (qb_ready),
      .out_item  (qb_item)
   );

   // Emit the minus sign, then one digit per cycle by compare and subtract, unless rsp_ready stalls.
   sitd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (qb_valid),
      .in_ready      (qb_ready),
      .in_item       (qb_item),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

// ===== src/sitd_front.sv =====
// Front end: takes a signed value, forms sign, magnitude and leading digit position.
// Depends on sitd_pkg.
`timescale 1ns / 1ps

module sitd_front import sitd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      out_valid,
   input  logic                      out_ready,
   output item_type                  out_item
);

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic     neg;
   logic [VALUE_W-1:0] mag;
   logic [POS_W-1:0]   top;

   always_comb begin
      neg = req_value[VALUE_W-1];
      mag = neg ? (VALUE_W'(0) - VALUE_W'(unsigned'(req_value)))
                : VALUE_W'(unsigned'(req_value));
      top = '0;
      // Leading digit sits at the number of powers 10^1..10^9 not above mag.
      for (int k = 1; k < 10; k++) begin
         if ({2'b00, mag} >= POW10[k]) begin
            top = top + POS_W'(1);
         end
      end
   end

   assign req_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff && !out_ready;
      item_in  = item_ff;
      if (req_valid && req_ready) begin
         valid_in     = 1'b1;
         item_in.neg  = neg;
         item_in.mag  = mag;
         item_in.top  = top;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

// ===== src/sitd_queue.sv =====
// Short queue of classified values between front and back.
// Depends on sitd_pkg.
`timescale 1ns / 1ps

module sitd_queue import sitd_pkg::*; #(
   parameter int unsigned DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   item_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_FULL);
   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

// ===== src/sitd_back.sv =====
// Back end: turns a classified value into characters, leading digit first.
// Depends on sitd_pkg.
`timescale 1ns / 1ps

module sitd_back import sitd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  item_type          in_item,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_text_char,
   output logic              rsp_last_char
);

   logic               busy_ff, busy_in;
   logic               minus_ff, minus_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;

   logic [WIDE_W-1:0]  pow;
   logic [WIDE_W-1:0]  mult [10];
   logic [3:0]         digit;
   logic [WIDE_W-1:0]  diff;
   logic               advance, finish;

   // Digit at this position: how many multiples of 10^pos fit in rem.
   always_comb begin
      pow   = POW10[pos_ff];
      digit = '0;
      for (int c = 0; c < 10; c++) begin
         mult[c] = WIDE_W'(pow * WIDE_W'(c));
      end
      for (int c = 1; c < 10; c++) begin
         if ({2'b00, rem_ff} >= mult[c]) begin
            digit = digit + 4'd1;
         end
      end
      diff = {2'b00, rem_ff} - mult[digit];
   end

   assign advance  = !valid_ff || rsp_ready;
   assign finish   = advance && busy_ff && !minus_ff && (pos_ff == '0);
   assign in_ready = !busy_ff || finish;

   always_comb begin
      busy_in  = busy_ff;
      minus_in = minus_ff;
      pos_in   = pos_ff;
      rem_in   = rem_ff;
      valid_in = valid_ff && !rsp_ready;
      char_in  = char_ff;
      last_in  = last_ff;
      if (advance && busy_ff) begin
         valid_in = 1'b1;
         if (minus_ff) begin
            char_in  = CHAR_MINUS;
            last_in  = 1'b0;
            minus_in = 1'b0;
         end else begin
            char_in = CHAR_W'(CHAR_ZERO + {2'b00, digit});
            last_in = (pos_ff == '0);
            rem_in  = diff[VALUE_W-1:0];
            pos_in  = pos_ff - POS_W'(1);
            busy_in = (pos_ff != '0);
         end
      end
      // Take the next value as the last character of this one leaves.
      if (in_valid && in_ready) begin
         busy_in  = 1'b1;
         minus_in = in_item.neg;
         pos_in   = in_item.top;
         rem_in   = in_item.mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         minus_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         minus_ff <= minus_in;
         valid_ff <= valid_in;
      end
      pos_ff  <= pos_in;
      rem_ff  <= rem_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last_char = last_ff;

endmodule
